// ===== sv/fraction_arithmetic_unit_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef FRACTION_ARITHMETIC_UNIT_MACROS_SVH
`define FRACTION_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define FAU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fraction unit check failed");

// Next-cycle implication, sampled on clk and quiet during reset.
`define FAU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fraction unit check failed");

`endif

// ===== sv/frac_pkg.sv =====
// ----------------------------------------------------------------------------
// Fraction unit package
// Types and fixed constants shared by the fraction arithmetic unit files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package frac_pkg;

	localparam int FIELD_BITS = 16;
	localparam int RES_BITS   = 33;

	typedef enum logic [1:0] {
		K_ADD = 2'd0,
		K_SUB = 2'd1,
		K_MUL = 2'd2,
		K_DIV = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_GCD_DEN,
		DP_GCD_RES,
		DP_DIV_AD,
		DP_DIV_BD,
		DP_DIV_NUM,
		DP_DIV_DEN,
		DP_MUL1,
		DP_MUL2,
		DP_MUL3,
		DP_SUM,
		DP_SUM_EQ,
		DP_OUT
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_G1W,
		ST_D1W,
		ST_D2W,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_SUM,
		ST_G2,
		ST_G2W,
		ST_D3W,
		ST_D4W,
		ST_FIN
	} state_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic  err;
		logic  den_eq;
		logic  gcd_done;
		logic  div_done;
		kind_t kind;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/frac_if.sv =====
// ----------------------------------------------------------------------------
// Fraction unit channels
// Valid/ready channels for operand requests and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface frac_req_if;
	logic                                     valid;
	logic                                     ready;
	logic [1:0]                               kind;
	logic signed [frac_pkg::FIELD_BITS-1:0]   a_num;
	logic signed [frac_pkg::FIELD_BITS-1:0]   a_den;
	logic signed [frac_pkg::FIELD_BITS-1:0]   b_num;
	logic signed [frac_pkg::FIELD_BITS-1:0]   b_den;

	modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface frac_res_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [frac_pkg::RES_BITS-1:0]   res_num;
	logic signed [frac_pkg::RES_BITS-1:0]   res_den;
	logic                                   status;

	modport source (output valid, res_num, res_den, status, input ready);
	modport sink (input valid, res_num, res_den, status, output ready);
endinterface

`default_nettype wire

// ===== sv/frac_gcd.sv =====
// ----------------------------------------------------------------------------
// Fraction unit GCD
// Binary GCD on two unsigned magnitudes, one shift or subtract per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frac_gcd #(
	parameter int DW = 34
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] a,
	input  wire logic [DW-1:0] b,
	output logic               done,
	output logic [DW-1:0]      g
);

	localparam int KW = $clog2(DW + 1);

	logic [DW-1:0] x_q, y_q;
	logic [KW-1:0] k_q;
	logic          busy_q, done_q;
	logic [DW-1:0] g_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && (x_q == '0 || y_q == '0)) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= a;
			y_q <= b;
			k_q <= '0;
		end else if (busy_q) begin
			if (x_q == '0 || y_q == '0) begin
				g_q <= (x_q | y_q) << k_q;
			end else if (!x_q[0] && !y_q[0]) begin
				// Common factors of two are set aside and restored at the end.
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q >= y_q) begin
				x_q <= x_q - y_q;
			end else begin
				y_q <= y_q - x_q;
			end
		end
	end

	assign done = done_q;
	assign g    = g_q;

endmodule

`default_nettype wire

// ===== sv/frac_div.sv =====
// ----------------------------------------------------------------------------
// Fraction unit divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frac_div #(
	parameter int DW = 34
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] n,
	input  wire logic [DW-1:0] d,
	output logic               done,
	output logic [DW-1:0]      q
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] n_q, d_q;
	logic [DW:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   rem_sh;
	logic          fit;

	assign rem_sh = {rem_q[DW-1:0], n_q[DW-1]};
	assign fit    = rem_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && cnt_q == CW'(DW - 1)) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n;
			d_q   <= d;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			rem_q <= fit ? rem_sh - {1'b0, d_q} : rem_sh;
			n_q   <= {n_q[DW-2:0], fit};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign done = done_q;
	assign q    = n_q;

endmodule

`default_nettype wire

// ===== sv/frac_dp.sv =====
// ----------------------------------------------------------------------------
// Fraction unit datapath
// Operand registers, shared multiplier, GCD and divider, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frac_dp #(
	parameter int W = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire frac_pkg::dp_cmd_t                      cmd,
	input  wire logic [1:0]                             kind,
	input  wire logic [frac_pkg::FIELD_BITS-1:0]        a_num,
	input  wire logic [frac_pkg::FIELD_BITS-1:0]        a_den,
	input  wire logic [frac_pkg::FIELD_BITS-1:0]        b_num,
	input  wire logic [frac_pkg::FIELD_BITS-1:0]        b_den,
	output frac_pkg::dp_stat_t                          stat,
	output logic signed [frac_pkg::RES_BITS-1:0]        res_num,
	output logic signed [frac_pkg::RES_BITS-1:0]        res_den,
	output logic                                        status
);

	localparam int OW = W + 1;
	localparam int DW = 2 * W + 2;
	localparam int RB = frac_pkg::RES_BITS;

	function automatic logic signed [OW-1:0] sx(input logic [frac_pkg::FIELD_BITS-1:0] v);
		logic [31:0] z;
		z = 32'(v);
		return {z[W-1], z[W-1:0]};
	endfunction

	function automatic logic signed [DW-1:0] ext(input logic signed [OW-1:0] v);
		return {{(DW - OW){v[OW-1]}}, v};
	endfunction

	function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
		return v[DW-1] ? -v : v;
	endfunction

	frac_pkg::kind_t      kind_q;
	logic signed [OW-1:0] an_q, ad_q, bn_q, bd_q, qa_q, qb_q;
	logic signed [DW-1:0] p1_q, p2_q, num_q, den_q;
	frac_pkg::dp_op_t     div_dst_q;
	logic                 div_neg_q;
	logic signed [RB-1:0] res_num_q, res_den_q;
	logic                 status_q;

	logic signed [OW-1:0] mul_a, mul_b;
	logic signed [DW-1:0] prod;
	logic                 addsub, err;
	logic                 gcd_start, gcd_done, div_start, div_done;
	logic [DW-1:0]        gcd_a, gcd_b, gcd_g, div_n, div_q;
	logic signed [DW-1:0] div_sq, div_arg;

	assign addsub = (kind_q == frac_pkg::K_ADD) || (kind_q == frac_pkg::K_SUB);
	assign err    = (ad_q == '0) || (bd_q == '0) || (kind_q == frac_pkg::K_DIV && bn_q == '0);

	always_comb begin
		mul_a = an_q;
		mul_b = bd_q;
		case (cmd.op)
			frac_pkg::DP_MUL1: begin
				mul_a = an_q;
				mul_b = addsub ? qb_q : (kind_q == frac_pkg::K_MUL ? bn_q : bd_q);
			end
			frac_pkg::DP_MUL2: begin
				mul_a = addsub ? bn_q : ad_q;
				mul_b = addsub ? qa_q : (kind_q == frac_pkg::K_MUL ? bd_q : bn_q);
			end
			frac_pkg::DP_MUL3: begin
				mul_a = ad_q;
				mul_b = qb_q;
			end
			default: begin
				mul_a = an_q;
				mul_b = bd_q;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	assign gcd_start = (cmd.op == frac_pkg::DP_GCD_DEN) || (cmd.op == frac_pkg::DP_GCD_RES);
	assign gcd_a = (cmd.op == frac_pkg::DP_GCD_DEN) ? mag(ext(ad_q)) : mag(num_q);
	assign gcd_b = (cmd.op == frac_pkg::DP_GCD_DEN) ? mag(ext(bd_q)) : mag(den_q);

	always_comb begin
		div_start = 1'b1;
		case (cmd.op)
			frac_pkg::DP_DIV_AD:  div_arg = ext(ad_q);
			frac_pkg::DP_DIV_BD:  div_arg = ext(bd_q);
			frac_pkg::DP_DIV_NUM: div_arg = num_q;
			frac_pkg::DP_DIV_DEN: div_arg = den_q;
			default: begin
				div_arg   = num_q;
				div_start = 1'b0;
			end
		endcase
	end
	assign div_n = mag(div_arg);

	frac_gcd #(.DW(DW)) u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.a      (gcd_a),
		.b      (gcd_b),
		.done   (gcd_done),
		.g      (gcd_g)
	);

	frac_div #(.DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (gcd_g),
		.done   (div_done),
		.q      (div_q)
	);

	// The divisions are exact, so the quotient takes the dividend's sign.
	assign div_sq = div_neg_q ? -$signed(div_q) : $signed(div_q);

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (div_dst_q)
				frac_pkg::DP_DIV_AD:  qa_q  <= div_sq[OW-1:0];
				frac_pkg::DP_DIV_BD:  qb_q  <= div_sq[OW-1:0];
				frac_pkg::DP_DIV_NUM: num_q <= div_sq;
				frac_pkg::DP_DIV_DEN: den_q <= div_sq;
				default: ;
			endcase
		end
		if (div_start) begin
			div_dst_q <= cmd.op;
			div_neg_q <= div_arg[DW-1];
		end
		case (cmd.op)
			frac_pkg::DP_LOAD: begin
				kind_q <= frac_pkg::kind_t'(kind);
				an_q   <= sx(a_num);
				ad_q   <= sx(a_den);
				bn_q   <= sx(b_num);
				bd_q   <= sx(b_den);
			end
			frac_pkg::DP_MUL1: begin
				if (addsub) p1_q <= prod;
				else num_q <= prod;
			end
			frac_pkg::DP_MUL2: begin
				if (addsub) p2_q <= prod;
				else den_q <= prod;
			end
			frac_pkg::DP_MUL3: den_q <= prod;
			frac_pkg::DP_SUM: begin
				num_q <= (kind_q == frac_pkg::K_ADD) ? p1_q + p2_q : p1_q - p2_q;
			end
			frac_pkg::DP_SUM_EQ: begin
				num_q <= (kind_q == frac_pkg::K_ADD) ? ext(an_q) + ext(bn_q)
					: ext(an_q) - ext(bn_q);
				den_q <= ext(ad_q);
			end
			frac_pkg::DP_OUT: begin
				res_num_q <= err ? '0 : RB'(num_q);
				res_den_q <= err ? '0 : RB'(den_q);
				status_q  <= err;
			end
			default: ;
		endcase
	end

	assign stat.err      = err;
	assign stat.den_eq   = (ad_q == bd_q);
	assign stat.gcd_done = gcd_done;
	assign stat.div_done = div_done;
	assign stat.kind     = kind_q;

	assign res_num = res_num_q;
	assign res_den = res_den_q;
	assign status  = status_q;

endmodule

`default_nettype wire

// ===== sv/frac_ctrl.sv =====
// ----------------------------------------------------------------------------
// Fraction unit controller
// Sequences the datapath steps and runs both channel handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frac_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	output logic                    res_valid,
	input  wire logic               res_ready,
	input  wire frac_pkg::dp_stat_t stat,
	output frac_pkg::dp_cmd_t       cmd
);

	frac_pkg::state_t state_q, state_d;
	logic             res_valid_q;
	logic             out_wr;
	logic             addsub;

	assign addsub = (stat.kind == frac_pkg::K_ADD) || (stat.kind == frac_pkg::K_SUB);
	assign out_wr = (state_q == frac_pkg::ST_FIN) && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= frac_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_wr) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = frac_pkg::DP_NOP;
		case (state_q)
			frac_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd.op  = frac_pkg::DP_LOAD;
					state_d = frac_pkg::ST_CHECK;
				end
			end
			frac_pkg::ST_CHECK: begin
				if (stat.err) begin
					state_d = frac_pkg::ST_FIN;
				end else if (addsub && stat.den_eq) begin
					cmd.op  = frac_pkg::DP_SUM_EQ;
					state_d = frac_pkg::ST_G2;
				end else if (addsub) begin
					cmd.op  = frac_pkg::DP_GCD_DEN;
					state_d = frac_pkg::ST_G1W;
				end else begin
					state_d = frac_pkg::ST_M1;
				end
			end
			frac_pkg::ST_G1W: begin
				if (stat.gcd_done) begin
					cmd.op  = frac_pkg::DP_DIV_AD;
					state_d = frac_pkg::ST_D1W;
				end
			end
			frac_pkg::ST_D1W: begin
				if (stat.div_done) begin
					cmd.op  = frac_pkg::DP_DIV_BD;
					state_d = frac_pkg::ST_D2W;
				end
			end
			frac_pkg::ST_D2W: begin
				if (stat.div_done) state_d = frac_pkg::ST_M1;
			end
			frac_pkg::ST_M1: begin
				cmd.op  = frac_pkg::DP_MUL1;
				state_d = frac_pkg::ST_M2;
			end
			frac_pkg::ST_M2: begin
				cmd.op  = frac_pkg::DP_MUL2;
				state_d = addsub ? frac_pkg::ST_M3 : frac_pkg::ST_G2;
			end
			frac_pkg::ST_M3: begin
				cmd.op  = frac_pkg::DP_MUL3;
				state_d = frac_pkg::ST_SUM;
			end
			frac_pkg::ST_SUM: begin
				cmd.op  = frac_pkg::DP_SUM;
				state_d = frac_pkg::ST_G2;
			end
			frac_pkg::ST_G2: begin
				cmd.op  = frac_pkg::DP_GCD_RES;
				state_d = frac_pkg::ST_G2W;
			end
			frac_pkg::ST_G2W: begin
				if (stat.gcd_done) begin
					cmd.op  = frac_pkg::DP_DIV_NUM;
					state_d = frac_pkg::ST_D3W;
				end
			end
			frac_pkg::ST_D3W: begin
				if (stat.div_done) begin
					cmd.op  = frac_pkg::DP_DIV_DEN;
					state_d = frac_pkg::ST_D4W;
				end
			end
			frac_pkg::ST_D4W: begin
				if (stat.div_done) state_d = frac_pkg::ST_FIN;
			end
			frac_pkg::ST_FIN: begin
				if (out_wr) begin
					cmd.op  = frac_pkg::DP_OUT;
					state_d = frac_pkg::ST_IDLE;
				end
			end
			default: state_d = frac_pkg::ST_IDLE;
		endcase
	end

	assign req_ready = (state_q == frac_pkg::ST_IDLE);
	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

// ===== sv/fraction_arithmetic_unit.sv =====
// Flow: a taken request is loaded and checked, and an error goes straight to the result. Sums over
// equal denominators are added at once; other sums pass a GCD of the denominators and two divisions,
// then three multiplications and an add or subtract; products and quotients use two multiplications.
// Every result but an error is then reduced by a GCD pass and two divisions, DW = 2*OPERAND_BITS+2 wide.
// One request is worked on at a time; a new request is taken while a result waits.
// Reset: arst_n clears the controller and the result valid flag at once.
// ----------------------------------------------------------------------------
// Fraction arithmetic unit
// Adds, subtracts, multiplies or divides two signed fractions and reduces the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fraction_arithmetic_unit #(
	parameter int OPERAND_BITS = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	frac_req_if.sink  req,
	frac_res_if.source res
);

	frac_pkg::dp_cmd_t  cmd;
	frac_pkg::dp_stat_t stat;

	frac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	frac_dp #(.W(OPERAND_BITS)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.kind    (req.kind),
		.a_num   (req.a_num),
		.a_den   (req.a_den),
		.b_num   (req.b_num),
		.b_den   (req.b_den),
		.stat    (stat),
		.res_num (res.res_num),
		.res_den (res.res_den),
		.status  (res.status)
	);

endmodule

`default_nettype wire

// ===== sv/frac_chk.sv =====
// ----------------------------------------------------------------------------
// Fraction unit checker
// Port-level checks on request and result behavior over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fraction_arithmetic_unit_macros.svh"

module frac_chk (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 req_valid,
	input wire logic                                 req_ready,
	input wire logic                                 res_valid,
	input wire logic                                 res_ready,
	input wire logic signed [frac_pkg::RES_BITS-1:0] res_num,
	input wire logic signed [frac_pkg::RES_BITS-1:0] res_den,
	input wire logic                                 status
);

	logic [2*frac_pkg::RES_BITS:0] res_all;

	assign res_all = {res_num, res_den, status};

	// One request is worked on at a time.
	`FAU_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
	// A stalled result holds its value.
	`FAU_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_all))
	// An error result carries zero terms.
	`FAU_ASSERT_IMP(a_err_zero, res_valid && status, res_num == '0 && res_den == '0)

endmodule

bind fraction_arithmetic_unit frac_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_num   (res.res_num),
	.res_den   (res.res_den),
	.status    (res.status)
);

`default_nettype wire
